FILE: design/lz77d_pkg.sv
// Shared types and constants for the LZ77 token stream decoder.
// Used by the front parser, the command queue, the back executor and the top level.
// No dependencies.
package lz77d_pkg;

   localparam int WINDOW_DEPTH    = 65536;
   localparam int ADDR_W          = $clog2(WINDOW_DEPTH);
   localparam int FILL_W          = $clog2(WINDOW_DEPTH) + 1;
   localparam int BYTE_W          = 8;
   localparam int NIBBLE_W        = 4;
   localparam int OFFSET_W        = 16;
   localparam int LEN_W           = 5;
   localparam int MIN_MATCH_W     = 5;
   localparam int MIN_MATCH_CAP   = 16;
   localparam int MIN_MATCH_RESET = 4;
   localparam int CMD_DEPTH       = 4;
   localparam int CMD_PTR_W       = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W       = $clog2(CMD_DEPTH + 1);

   typedef enum logic [1:0] {
      CMD_LITERAL = 2'd0,
      CMD_COPY    = 2'd1,
      CMD_ERROR   = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type            kind;
      logic [BYTE_W-1:0]       data_byte;
      logic [OFFSET_W-1:0]     offset;
      logic [LEN_W-1:0]        length;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

FILE: design/lz77d_front.sv
// Front parser: accepts compressed bytes, tracks the sequence phase and the
// history fill, and turns each byte into at most one command for the back.
// Depends on lz77d_pkg.
module lz77d_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  logic [lz77d_pkg::BYTE_W-1:0]        in_byte,
   input  logic                                block_start,
   input  logic                                csr_wr_en,
   input  logic [lz77d_pkg::MIN_MATCH_W-1:0]   csr_wr_data,
   output logic                                cmd_push,
   output lz77d_pkg::cmd_type                  cmd_out
);

   typedef enum logic [3:0] {
      PH_TOKEN   = 4'b0001,
      PH_LITERAL = 4'b0010,
      PH_OFF_LO  = 4'b0100,
      PH_OFF_HI  = 4'b1000
   } phase_type;

   phase_type                            phase_ff, phase_in, cur_phase;
   logic [lz77d_pkg::NIBBLE_W-1:0]       lit_left_ff, lit_left_in;
   logic [lz77d_pkg::NIBBLE_W-1:0]       nibble_ff, nibble_in;
   logic [lz77d_pkg::BYTE_W-1:0]         off_lo_ff, off_lo_in;
   logic [lz77d_pkg::FILL_W-1:0]         fill_ff, fill_in, cur_fill;
   logic [lz77d_pkg::MIN_MATCH_W-1:0]    min_match_ff, min_match_in;
   logic [lz77d_pkg::MIN_MATCH_W-1:0]    min_clamped;
   logic [lz77d_pkg::LEN_W-1:0]          copy_len;
   logic [lz77d_pkg::OFFSET_W-1:0]       offset;

   // Saturating add to the history fill count.
   function automatic logic [lz77d_pkg::FILL_W-1:0] fill_add(
      input logic [lz77d_pkg::FILL_W-1:0] a,
      input logic [lz77d_pkg::LEN_W-1:0]  n
   );
      logic [lz77d_pkg::FILL_W:0] sum;
      sum = {1'b0, a} + (lz77d_pkg::FILL_W + 1)'(n);
      if (sum > (lz77d_pkg::FILL_W + 1)'(lz77d_pkg::WINDOW_DEPTH)) begin
         return lz77d_pkg::FILL_W'(lz77d_pkg::WINDOW_DEPTH);
      end
      return sum[lz77d_pkg::FILL_W-1:0];
   endfunction

   assign min_clamped = (min_match_ff > lz77d_pkg::MIN_MATCH_W'(lz77d_pkg::MIN_MATCH_CAP))
                        ? lz77d_pkg::MIN_MATCH_W'(lz77d_pkg::MIN_MATCH_CAP) : min_match_ff;
   assign copy_len    = lz77d_pkg::LEN_W'(nibble_ff) + lz77d_pkg::LEN_W'(min_clamped);
   assign offset      = {in_byte, off_lo_ff};
   assign cur_phase   = block_start ? PH_TOKEN : phase_ff;
   assign cur_fill    = block_start ? '0 : fill_ff;

   always_comb begin
      phase_in          = phase_ff;
      lit_left_in       = lit_left_ff;
      nibble_in         = nibble_ff;
      off_lo_in         = off_lo_ff;
      fill_in           = fill_ff;
      min_match_in      = csr_wr_en ? csr_wr_data : min_match_ff;
      cmd_push          = 1'b0;
      cmd_out.kind      = lz77d_pkg::CMD_LITERAL;
      cmd_out.data_byte = in_byte;
      cmd_out.offset    = offset;
      cmd_out.length    = copy_len;
      if (accept) begin
         fill_in = cur_fill;
         case (cur_phase)
            PH_TOKEN: begin
               lit_left_in = in_byte[lz77d_pkg::NIBBLE_W-1:0];
               nibble_in   = in_byte[lz77d_pkg::BYTE_W-1:lz77d_pkg::NIBBLE_W];
               phase_in    = (in_byte[lz77d_pkg::NIBBLE_W-1:0] != '0) ? PH_LITERAL : PH_OFF_LO;
            end
            PH_LITERAL: begin
               cmd_push    = 1'b1;
               fill_in     = fill_add(cur_fill, lz77d_pkg::LEN_W'(1));
               lit_left_in = lit_left_ff - 1'b1;
               if (lit_left_ff <= lz77d_pkg::NIBBLE_W'(1)) begin
                  phase_in = PH_OFF_LO;
               end
            end
            PH_OFF_LO: begin
               off_lo_in = in_byte;
               phase_in  = PH_OFF_HI;
            end
            PH_OFF_HI: begin
               phase_in = PH_TOKEN;
               if (offset == '0 || {1'b0, offset} > cur_fill) begin
                  cmd_push     = 1'b1;
                  cmd_out.kind = lz77d_pkg::CMD_ERROR;
               end else if (copy_len != '0) begin
                  cmd_push     = 1'b1;
                  cmd_out.kind = lz77d_pkg::CMD_COPY;
                  fill_in      = fill_add(cur_fill, copy_len);
               end
            end
            default: begin
               phase_in = PH_TOKEN;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_TOKEN;
         lit_left_ff  <= '0;
         nibble_ff    <= '0;
         off_lo_ff    <= '0;
         fill_ff      <= '0;
         min_match_ff <= lz77d_pkg::MIN_MATCH_W'(lz77d_pkg::MIN_MATCH_RESET);
      end else begin
         phase_ff     <= phase_in;
         lit_left_ff  <= lit_left_in;
         nibble_ff    <= nibble_in;
         off_lo_ff    <= off_lo_in;
         fill_ff      <= fill_in;
         min_match_ff <= min_match_in;
      end
   end

endmodule

FILE: design/lz77d_cmd_fifo.sv
// Short command queue between the front parser and the back executor.
// Depends on lz77d_pkg.
module lz77d_cmd_fifo (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  lz77d_pkg::cmd_type            push_cmd,
   input  logic                          pop,
   output lz77d_pkg::cmd_type            head_cmd,
   output lz77d_pkg::queue_status_type   status
);

   lz77d_pkg::cmd_type                  entries [lz77d_pkg::CMD_DEPTH];
   logic [lz77d_pkg::CMD_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [lz77d_pkg::CMD_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [lz77d_pkg::CMD_CNT_W-1:0]     count_ff, count_in;
   logic                                do_push, do_pop;

   assign status.full  = (count_ff == lz77d_pkg::CMD_CNT_W'(lz77d_pkg::CMD_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_cmd     = entries[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: design/lz77d_back.sv
// Back executor: carries out literal, copy and error commands, owns the
// history memory and the result register. Depends on lz77d_pkg.
module lz77d_back (
   input  logic                              clock,
   input  logic                              reset,
   input  lz77d_pkg::cmd_type                head_cmd,
   input  lz77d_pkg::queue_status_type       queue_status,
   output logic                              pop,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [lz77d_pkg::BYTE_W-1:0]      rsp_out_byte,
   output logic                              rsp_last,
   output logic                              rsp_error
);

   typedef enum logic [2:0] {
      BK_IDLE = 3'b001,
      BK_READ = 3'b010,
      BK_DATA = 3'b100
   } back_state_type;

   logic [lz77d_pkg::BYTE_W-1:0]     hist_mem [lz77d_pkg::WINDOW_DEPTH];

   back_state_type                   state_ff, state_in;
   logic [lz77d_pkg::ADDR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [lz77d_pkg::ADDR_W-1:0]     dist_ff, dist_in;
   logic [lz77d_pkg::LEN_W-1:0]      left_ff, left_in;
   logic [lz77d_pkg::BYTE_W-1:0]     rd_data_ff;
   logic                             out_valid_ff, out_valid_in;
   logic [lz77d_pkg::BYTE_W-1:0]     out_byte_ff, out_byte_in;
   logic                             out_last_ff, out_last_in;
   logic                             out_error_ff, out_error_in;
   logic                             out_free, load;
   logic                             mem_we, mem_re;
   logic [lz77d_pkg::BYTE_W-1:0]     mem_wdata;
   logic [lz77d_pkg::ADDR_W-1:0]     rd_addr;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign rd_addr  = wr_ptr_ff - dist_ff;

   always_comb begin
      state_in     = state_ff;
      wr_ptr_in    = wr_ptr_ff;
      dist_in      = dist_ff;
      left_in      = left_ff;
      pop          = 1'b0;
      load         = 1'b0;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_wdata    = head_cmd.data_byte;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      out_error_in = out_error_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!queue_status.empty && out_free) begin
               pop = 1'b1;
               case (head_cmd.kind)
                  lz77d_pkg::CMD_LITERAL: begin
                     mem_we       = 1'b1;
                     wr_ptr_in    = wr_ptr_ff + 1'b1;
                     load         = 1'b1;
                     out_byte_in  = head_cmd.data_byte;
                     out_last_in  = 1'b1;
                     out_error_in = 1'b0;
                  end
                  lz77d_pkg::CMD_COPY: begin
                     // The offset fits the address width, so it is taken over unchanged as the distance.
                     dist_in  = lz77d_pkg::ADDR_W'(head_cmd.offset);
                     left_in  = head_cmd.length;
                     state_in = BK_READ;
                  end
                  default: begin
                     load         = 1'b1;
                     out_byte_in  = '0;
                     out_last_in  = 1'b1;
                     out_error_in = 1'b1;
                  end
               endcase
            end
         end
         BK_READ: begin
            mem_re   = 1'b1;
            state_in = BK_DATA;
         end
         BK_DATA: begin
            if (out_free) begin
               // The byte is written before the next read, so overlapping copies
               // see the data they have just produced.
               mem_we       = 1'b1;
               mem_wdata    = rd_data_ff;
               wr_ptr_in    = wr_ptr_ff + 1'b1;
               load         = 1'b1;
               out_byte_in  = rd_data_ff;
               out_last_in  = (left_ff == lz77d_pkg::LEN_W'(1));
               out_error_in = 1'b0;
               left_in      = left_ff - 1'b1;
               state_in     = (left_ff == lz77d_pkg::LEN_W'(1)) ? BK_IDLE : BK_READ;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
      if (load) begin
         out_valid_in = 1'b1;
      end else if (out_free) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist_mem[wr_ptr_ff] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= hist_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff  <= out_byte_in;
      out_last_ff  <= out_last_in;
      out_error_ff <= out_error_in;
      dist_ff      <= dist_in;
      left_ff      <= left_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         wr_ptr_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_ptr_ff    <= wr_ptr_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_last     = out_last_ff;
   assign rsp_error    = out_error_ff;

endmodule

FILE: design/lz77_token_stream_decoder.sv
// Top level of the LZ77 token stream decoder: front parser, command queue
// and back executor. Depends on lz77d_pkg, lz77d_front, lz77d_cmd_fifo, lz77d_back.
//
//   channel   direction  handshake            payload
//   req       in         req_valid/req_stall  req_in_byte, req_block_start
//   rsp       out        rsp_valid/rsp_stall  rsp_out_byte, rsp_last, rsp_error
//   csr       in         csr_wr_en            csr_wr_data (minimum match length)
//
// A literal's command enters the four-entry command queue when its byte is accepted; the
// back executor pops it and registers its result at the same edge, so literals flow one
// per cycle while the output is not stalled and no copy is running. A match copy leaves
// the queue from the idle state, then takes a read and a data state per byte, set by the
// registered read of the history memory ahead of the write of each copied byte.
// Input stalls only while the command queue is full; output stalls hold the
// result register and the back executor. Synchronous reset clears control
// state; the history memory needs no clearing pass.
module lz77_token_stream_decoder (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [lz77d_pkg::BYTE_W-1:0]        req_in_byte,
   input  logic                                req_block_start,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [lz77d_pkg::BYTE_W-1:0]        rsp_out_byte,
   output logic                                rsp_last,
   output logic                                rsp_error,
   input  logic                                csr_wr_en,
   input  logic [lz77d_pkg::MIN_MATCH_W-1:0]   csr_wr_data
);

   lz77d_pkg::cmd_type            push_cmd, head_cmd;
   lz77d_pkg::queue_status_type   queue_status;
   logic                          accept, cmd_push, cmd_pop;

   assign req_stall = queue_status.full;
   assign accept    = req_valid && !req_stall;

   lz77d_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .in_byte     (req_in_byte),
      .block_start (req_block_start),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd_push    (cmd_push),
      .cmd_out     (push_cmd)
   );

   lz77d_cmd_fifo u_cmd_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (push_cmd),
      .pop      (cmd_pop),
      .head_cmd (head_cmd),
      .status   (queue_status)
   );

   lz77d_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_cmd     (head_cmd),
      .queue_status (queue_status),
      .pop          (cmd_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last),
      .rsp_error    (rsp_error)
   );

   // An error result always carries a zero byte and closes its input byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_out_byte == '0 && rsp_last)
      else $error("error result with nonzero byte or without last");

   // The front never pushes a command into a full queue.
   assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> !queue_status.full)
      else $error("command pushed into a full queue");

   // The back only pops commands that are present.
   assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> !queue_status.empty)
      else $error("command popped from an empty queue");

   // No result is offered in the cycle after reset.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

FILE: tb/lz77_token_stream_decoder_tb.sv
// Self-checking testbench for lz77_token_stream_decoder: a tracker class predicts the decoded
// bytes for every accepted compressed byte, and plain tasks drive the req, rsp and csr ports.
// Depends on lz77d_pkg and the lz77_token_stream_decoder RTL.
module lz77_token_stream_decoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned SETTLE_CYCLES = 80;

   typedef enum logic [3:0] {
      WANT_TOKEN     = 4'b0001,
      WANT_LITERAL   = 4'b0010,
      WANT_OFFSET_LO = 4'b0100,
      WANT_OFFSET_HI = 4'b1000
   } parse_step_type;

   typedef struct packed {
      logic [lz77d_pkg::BYTE_W-1:0] data;
      logic                         last;
      logic                         err;
   } decoded_type;

   class decoded_stream_tracker;
      logic [lz77d_pkg::BYTE_W-1:0]   window [lz77d_pkg::WINDOW_DEPTH];
      decoded_type                    expected [$];
      parse_step_type                 step;
      logic [lz77d_pkg::NIBBLE_W-1:0] literals_due;
      logic [lz77d_pkg::NIBBLE_W-1:0] copy_nibble;
      logic [lz77d_pkg::BYTE_W-1:0]   offset_lo;
      logic [lz77d_pkg::ADDR_W-1:0]   wr_addr;
      int unsigned                    fill_count;
      int unsigned                    min_match;
      int                             errors;

      function new();
         min_match = lz77d_pkg::MIN_MATCH_RESET;
         errors = 0;
         restart_block();
      endfunction

      function void restart_block();
         step = WANT_TOKEN;
         literals_due = '0;
         copy_nibble = '0;
         offset_lo = '0;
         wr_addr = '0;
         fill_count = 0;
      endfunction

      // Every decoded byte lands in the history window and is expected on rsp.
      function void emit(logic [lz77d_pkg::BYTE_W-1:0] d, logic is_last);
         window[wr_addr] = d;
         wr_addr = wr_addr + 1'b1;
         if (fill_count < lz77d_pkg::WINDOW_DEPTH) fill_count++;
         expected.insert(expected.size(), decoded_type'({d, is_last, 1'b0}));
      endfunction

      function void take_compressed_byte(logic [lz77d_pkg::BYTE_W-1:0] b,
                                         logic first_of_block);
         int unsigned offset;
         int unsigned copy_len;
         int unsigned cap;
         int unsigned i;
         logic [lz77d_pkg::ADDR_W-1:0] src;
         if (first_of_block) restart_block();
         case (step)
            WANT_TOKEN: begin
               literals_due = b[lz77d_pkg::NIBBLE_W-1:0];
               copy_nibble = b[lz77d_pkg::BYTE_W-1:lz77d_pkg::NIBBLE_W];
               step = (literals_due != 0) ? WANT_LITERAL : WANT_OFFSET_LO;
            end
            WANT_LITERAL: begin
               emit(b, 1'b1);
               if (literals_due != 0) literals_due = literals_due - 1'b1;
               if (literals_due == 0) step = WANT_OFFSET_LO;
            end
            WANT_OFFSET_LO: begin
               offset_lo = b;
               step = WANT_OFFSET_HI;
            end
            default: begin
               offset = 32'({b, offset_lo});
               cap = (min_match > lz77d_pkg::MIN_MATCH_CAP) ? lz77d_pkg::MIN_MATCH_CAP
                                                            : min_match;
               copy_len = 32'(copy_nibble) + cap;
               step = WANT_TOKEN;
               if (offset == 0 || offset > fill_count) begin
                  expected.insert(expected.size(), decoded_type'({8'h00, 1'b1, 1'b1}));
               end else begin
                  for (i = 0; i < copy_len; i++) begin
                     src = wr_addr - lz77d_pkg::ADDR_W'(offset);
                     emit(window[src], (i + 1 == copy_len));
                  end
               end
            end
         endcase
      endfunction

      function void check_decoded_byte(logic [lz77d_pkg::BYTE_W-1:0] d, logic is_last,
                                       logic err);
         decoded_type want;
         if (expected.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual byte %0h last %0b error %0b",
                     $time, d, is_last, err);
            errors++;
            return;
         end
         want = expected.pop_front();
         if (d !== want.data) begin
            $display("%0t: out_byte expected %0h actual %0h", $time, want.data, d);
            errors++;
         end
         if (is_last !== want.last) begin
            $display("%0t: last expected %0b actual %0b", $time, want.last, is_last);
            errors++;
         end
         if (err !== want.err) begin
            $display("%0t: error expected %0b actual %0b", $time, want.err, err);
            errors++;
         end
      endfunction
   endclass

   logic                              clock = 1'b0;
   logic                              reset;
   logic                              req_valid;
   logic                              req_stall;
   logic [lz77d_pkg::BYTE_W-1:0]      req_in_byte;
   logic                              req_block_start;
   logic                              rsp_valid;
   logic                              rsp_stall;
   logic [lz77d_pkg::BYTE_W-1:0]      rsp_out_byte;
   logic                              rsp_last;
   logic                              rsp_error;
   logic                              csr_wr_en;
   logic [lz77d_pkg::MIN_MATCH_W-1:0] csr_wr_data;

   decoded_stream_tracker tracker = new();
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned items_sent = 0;

   lz77_token_stream_decoder dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .req_block_start (req_block_start),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last        (rsp_last),
      .rsp_error       (rsp_error),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Outputs read here still hold their values from before this edge.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            tracker.check_decoded_byte(rsp_out_byte, rsp_last, rsp_error);
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   initial begin
      #10_000_000;
      $display("FAIL lz77_token_stream_decoder");
      $finish;
   end

   task automatic send_byte(input logic [lz77d_pkg::BYTE_W-1:0] b,
                            input logic first_of_block);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      req_block_start <= first_of_block;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.take_compressed_byte(b, first_of_block);
      items_sent++;
   endtask

   task automatic pause_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.expected.size() != 0) @(posedge clock);
   endtask

   // A copy may still be running after the last expected byte has arrived.
   task automatic settle();
      pause_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_min_match(input logic [lz77d_pkg::MIN_MATCH_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tracker.min_match = 32'(value);
   endtask

   // One well-formed sequence with random content; it may end the block after its literals.
   task automatic send_sequence(input logic first_of_block, output logic block_ended);
      logic [lz77d_pkg::NIBBLE_W-1:0] lit_count;
      logic [lz77d_pkg::NIBBLE_W-1:0] nibble;
      logic [lz77d_pkg::OFFSET_W-1:0] offset;
      int unsigned                    fill;
      int unsigned                    pick;
      int unsigned                    k;
      lit_count = lz77d_pkg::NIBBLE_W'($urandom_range(15));
      nibble = lz77d_pkg::NIBBLE_W'($urandom_range(15));
      send_byte({nibble, lit_count}, first_of_block);
      for (k = 0; k < lit_count; k++)
         send_byte(lz77d_pkg::BYTE_W'($urandom_range(255)), 1'b0);
      block_ended = ($urandom_range(19) == 0);
      if (block_ended) return;
      fill = tracker.fill_count;
      pick = $urandom_range(99);
      if (pick < 5)
         offset = '0;
      else if (pick < 12 || fill == 0)
         offset = (fill >= 65535) ? '0
                                  : lz77d_pkg::OFFSET_W'($urandom_range(65535, fill + 1));
      else if (pick < 60)
         offset = lz77d_pkg::OFFSET_W'($urandom_range((fill < 8) ? fill : 8, 1));
      else
         offset = lz77d_pkg::OFFSET_W'($urandom_range(fill, 1));
      send_byte(offset[7:0], 1'b0);
      send_byte(offset[15:8], 1'b0);
   endtask

   task automatic run_traffic(input int unsigned n, input int unsigned noise_pct,
                              input int unsigned drain_pct);
      int unsigned goal;
      int unsigned burst;
      int unsigned k;
      logic        fresh;
      logic        ended;
      goal = items_sent + n;
      fresh = 1'b1;
      while (items_sent < goal) begin
         if ($urandom_range(99) < noise_pct) begin
            burst = $urandom_range(4, 1);
            for (k = 0; k < burst; k++)
               send_byte(lz77d_pkg::BYTE_W'($urandom_range(255)), ($urandom_range(3) == 0));
            ended = 1'b1;
         end else begin
            send_sequence(fresh, ended);
         end
         fresh = ended;
         if ($urandom_range(99) < drain_pct) pause_until_drained();
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_in_byte <= '0;
      req_block_start <= 1'b0;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed transactions with the minimum match length at its reset value.
      // Two literals, then an overlapping copy at distance one.
      send_byte(8'h02, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h00, 1'b0);
      // No literals and an offset of zero.
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      // Longest nibble, one literal, copy reaching three bytes back.
      send_byte(8'hF1, 1'b0);
      send_byte(8'hA5, 1'b0);
      send_byte(8'h03, 1'b0);
      send_byte(8'h00, 1'b0);
      // Offset far beyond what has been decoded.
      send_byte(8'h10, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      // The block ends after its literals; the new one copies before decoding anything.
      send_byte(8'h01, 1'b0);
      send_byte(8'h5A, 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte(8'h01, 1'b0);
      send_byte(8'h00, 1'b0);
      settle();

      // Zero minimum: a zero nibble copies nothing, a nibble of one copies one byte.
      write_min_match(5'd0);
      send_byte(8'h01, 1'b1);
      send_byte(8'h3C, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h10, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h00, 1'b0);
      run_traffic(28, 5, 0);
      settle();

      write_min_match(5'd16);
      send_idle_pct = 74;
      run_traffic(30, 5, 0);
      settle();

      // Minimum above the cap acts as the cap, so this copy is the longest possible.
      write_min_match(5'd31);
      send_idle_pct = 0;
      recv_stall_pct = 74;
      send_byte(8'hF1, 1'b1);
      send_byte(8'hC3, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h00, 1'b0);
      run_traffic(30, 5, 0);
      settle();

      write_min_match(lz77d_pkg::MIN_MATCH_W'($urandom_range(31)));
      send_idle_pct = 27;
      recv_stall_pct = 27;
      run_traffic(32, 5, 30);
      settle();

      write_min_match(lz77d_pkg::MIN_MATCH_W'(lz77d_pkg::MIN_MATCH_RESET));
      run_traffic(32, 30, 0);
      settle();

      if (tracker.errors == 0 && tracker.expected.size() == 0) begin
         $display("PASS lz77_token_stream_decoder");
      end else begin
         if (tracker.expected.size() != 0)
            $display("%0t: %0d expected results never arrived", $time,
                     tracker.expected.size());
         $display("FAIL lz77_token_stream_decoder");
      end
      $finish;
   end

endmodule
